// ===== rtl/core/rts_pkg.sv =====
// Shared types and constants for the right triangle solver.
package rts_pkg;

  localparam int IN_W    = 32;
  localparam int SIDE_OW = 33;
  localparam int ANGLE_W = 23;
  localparam int PERIM_W = 34;
  localparam int AREA_W  = 63;

  // CORDIC datapath width and the bit that normalization brings the larger leg to.
  localparam int CW       = 64;
  localparam int NORM_TOP = 58;
  localparam int ZW       = 25;
  localparam int ATAN_N   = 32;

  localparam logic             CMD_LONG  = 1'b0;
  localparam logic             CMD_SHORT = 1'b1;

  localparam logic [ANGLE_W-1:0] ANGLE_NINETY = 23'd5898240;
  localparam logic [SIDE_OW-1:0] SIDE_MAX     = {SIDE_OW{1'b1}};
  localparam logic [PERIM_W-1:0] PERIM_MAX    = {PERIM_W{1'b1}};
  localparam logic [AREA_W-1:0]  AREA_MAX     = {AREA_W{1'b1}};

  localparam logic [ANGLE_W-1:0] ATAN_DEG_Q16 [ATAN_N] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
    23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
    23'd1, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0
  };

  typedef struct packed {
    logic [SIDE_OW-1:0] third_side;
    logic [ANGLE_W-1:0] alpha_deg;
    logic [ANGLE_W-1:0] beta_deg;
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0]  area;
    logic               status;
  } out_word_t;

endpackage

// ===== rtl/core/rts_in_if.sv =====
// Input channel carrying one triangle word.
interface rts_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [rts_pkg::IN_W-1:0]   side_one;
  logic [rts_pkg::IN_W-1:0]   side_two;
  modport source (output valid, command, side_one, side_two, input ready);
  modport sink (input valid, command, side_one, side_two, output ready);
endinterface

// ===== rtl/core/rts_out_if.sv =====
// Result channel carrying one solved triangle word.
interface rts_out_if;
  logic                           valid;
  logic                           ready;
  logic [rts_pkg::SIDE_OW-1:0]    third_side;
  logic [rts_pkg::ANGLE_W-1:0]    alpha_deg;
  logic [rts_pkg::ANGLE_W-1:0]    beta_deg;
  logic [rts_pkg::PERIM_W-1:0]    perimeter;
  logic [rts_pkg::AREA_W-1:0]     area;
  logic                           status;
  modport source (output valid, third_side, alpha_deg, beta_deg, perimeter, area, status,
                  input ready);
  modport sink (input valid, third_side, alpha_deg, beta_deg, perimeter, area, status,
                output ready);
endinterface

// ===== rtl/core/rts_pipe_reg.sv =====
// Plain pipeline register stage with valid/ready flow control.
module rts_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         v_i,
  output logic         ready_o,
  input  logic [W-1:0] d_i,
  output logic         v_o,
  input  logic         ready_i,
  output logic [W-1:0] d_o
);
  logic         v_r;
  logic [W-1:0] d_r;

  assign ready_o = !v_r || ready_i;
  assign v_o     = v_r;
  assign d_o     = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && v_i) begin
      d_r <= d_i;
    end
  end
endmodule

// ===== rtl/core/rts_sqrt_cell.sv =====
// One cell of the square root chain: settles one bit of the root.
module rts_sqrt_cell #(
  parameter int RB     = 33,
  parameter int IDX    = 0,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_i,
  output logic              ready_o,
  input  logic [2*RB-1:0]   n_i,
  input  logic [RB:0]       rem_i,
  input  logic [RB-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              v_o,
  input  logic              ready_i,
  output logic [2*RB-1:0]   n_o,
  output logic [RB:0]       rem_o,
  output logic [RB-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int NW = 2 * RB;

  logic              v_r;
  logic [NW-1:0]     n_r;
  logic [RB:0]       rem_r, rem_nxt;
  logic [RB-1:0]     root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [RB+2:0]     cur, trial, diff;

  always_comb begin
    cur   = {rem_i, n_i[NW-1-2*IDX -: 2]};
    trial = {1'b0, root_i, 2'b01};
    diff  = cur - trial;
    if (cur >= trial) begin
      rem_nxt  = diff[RB:0];
      root_nxt = {root_i[RB-2:0], 1'b1};
    end else begin
      rem_nxt  = cur[RB:0];
      root_nxt = {root_i[RB-2:0], 1'b0};
    end
  end

  assign ready_o = !v_r || ready_i;
  assign v_o     = v_r;
  assign n_o     = n_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && v_i) begin
      n_r    <= n_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end
endmodule

// ===== rtl/core/rts_norm_cell.sv =====
// One normalization cell: shifts both legs left by K when the larger leg has room.
module rts_norm_cell #(
  parameter int K      = 1,
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   v_i,
  output logic                   ready_o,
  input  logic [rts_pkg::CW-1:0] x_i,
  input  logic [rts_pkg::CW-1:0] y_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   v_o,
  input  logic                   ready_i,
  output logic [rts_pkg::CW-1:0] x_o,
  output logic [rts_pkg::CW-1:0] y_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic                   v_r;
  logic [rts_pkg::CW-1:0] x_r, y_r, x_nxt, y_nxt, big;
  logic [SIDE_W-1:0]      side_r;

  // The OR of the legs has the same leading one as the larger leg.
  always_comb begin
    big = x_i | y_i;
    if ((big >> (rts_pkg::NORM_TOP + 1 - K)) == '0) begin
      x_nxt = x_i << K;
      y_nxt = y_i << K;
    end else begin
      x_nxt = x_i;
      y_nxt = y_i;
    end
  end

  assign ready_o = !v_r || ready_i;
  assign v_o     = v_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign side_o  = side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && v_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      side_r <= side_i;
    end
  end
endmodule

// ===== rtl/core/rts_cordic_cell.sv =====
// One CORDIC vectoring cell: performs rotation step I on the leg pair.
module rts_cordic_cell #(
  parameter int I      = 0,
  parameter int SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          v_i,
  output logic                          ready_o,
  input  logic [rts_pkg::CW-1:0]        x_i,
  input  logic [rts_pkg::CW-1:0]        y_i,
  input  logic signed [rts_pkg::ZW-1:0] z_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          v_o,
  input  logic                          ready_i,
  output logic [rts_pkg::CW-1:0]        x_o,
  output logic [rts_pkg::CW-1:0]        y_o,
  output logic signed [rts_pkg::ZW-1:0] z_o,
  output logic [SIDE_W-1:0]             side_o
);
  logic                          v_r;
  logic [rts_pkg::CW-1:0]        x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [rts_pkg::ZW-1:0] z_r, z_nxt, step;
  logic [SIDE_W-1:0]             side_r;

  // Once the residual reaches zero the remaining steps leave everything as is.
  always_comb begin
    xs   = x_i >> I;
    ys   = $unsigned($signed(y_i) >>> I);
    step = $signed({2'b00, rts_pkg::ATAN_DEG_Q16[I]});
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (y_i != '0) begin
      if (!y_i[rts_pkg::CW-1]) begin
        x_nxt = x_i + ys;
        y_nxt = y_i - xs;
        z_nxt = z_i + step;
      end else begin
        x_nxt = x_i - ys;
        y_nxt = y_i + xs;
        z_nxt = z_i - step;
      end
    end
  end

  assign ready_o = !v_r || ready_i;
  assign v_o     = v_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && v_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end
endmodule

// ===== rtl/core/right_triangle_solver.sv =====
// Top level of the right triangle solver pipeline.
// The solver takes one triangle word per cycle while the output is not stalled and returns one
// result word per input, in order. Its depth is set by the square root chain, one cell per
// root bit, the six-cell normalization shifter and the CORDIC chain, one cell per rotation
// step; the squares sit in a stage of their own and the leg product in the stage that resolves
// the sides and perimeter. Every stage has its own valid bit and passes ready upstream, so a
// stalled result only holds the stages that are full behind it and bubbles are squeezed out.
module right_triangle_solver #(
  parameter int LENGTH_WIDTH     = 32,
  parameter int ANGLE_ITERATIONS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  rts_in_if.sink     in_ch,
  rts_out_if.source  out_ch
);
  localparam int L   = LENGTH_WIDTH;
  localparam int RB  = L + 1;
  localparam int NW  = 2 * RB;
  localparam int N   = ANGLE_ITERATIONS;
  localparam int TW  = (RB > rts_pkg::SIDE_OW) ? RB : rts_pkg::SIDE_OW;
  localparam int PMW = (L + 2 > rts_pkg::PERIM_W) ? L + 2 : rts_pkg::PERIM_W;
  localparam int AXW = (2 * L > 66) ? 2 * L : 66;
  localparam int NS  = 6;

  typedef struct packed {
    logic         mode;
    logic         deg;
    logic [L-1:0] s1;
    logic [L-1:0] s2;
  } st0_t;

  typedef struct packed {
    st0_t           s;
    logic [2*L-1:0] sq1;
    logic [2*L-1:0] sq2;
  } sq_t;

  typedef struct packed {
    logic           deg;
    logic [L-1:0]   a;
    logic [L-1:0]   b;
    logic [RB-1:0]  third;
    logic [L+1:0]   perim;
    logic [2*L-1:0] prod;
  } post_t;

  // Input stage.
  st0_t st0_nxt, st0_d;
  logic st0_v, st0_rdy;

  always_comb begin
    st0_nxt.mode = in_ch.command;
    st0_nxt.s1   = L'(in_ch.side_one);
    st0_nxt.s2   = L'(in_ch.side_two);
    if (in_ch.command == rts_pkg::CMD_SHORT) begin
      st0_nxt.deg = (st0_nxt.s1 == '0) || (st0_nxt.s1 < st0_nxt.s2);
    end else begin
      st0_nxt.deg = (st0_nxt.s1 == '0) && (st0_nxt.s2 == '0);
    end
  end

  rts_pipe_reg #(.W($bits(st0_t))) u_in_reg (
    .clk(clk), .rst_n(rst_n), .v_i(in_ch.valid), .ready_o(in_ch.ready), .d_i(st0_nxt),
    .v_o(st0_v), .ready_i(st0_rdy), .d_o(st0_d)
  );

  // Squares of both given sides.
  sq_t  sq_nxt, sq_d;
  logic sq_v, sq_rdy;

  always_comb begin
    sq_nxt.s   = st0_d;
    sq_nxt.sq1 = (2*L)'(st0_d.s1) * (2*L)'(st0_d.s1);
    sq_nxt.sq2 = (2*L)'(st0_d.s2) * (2*L)'(st0_d.s2);
  end

  rts_pipe_reg #(.W($bits(sq_t))) u_sq_reg (
    .clk(clk), .rst_n(rst_n), .v_i(st0_v), .ready_o(st0_rdy), .d_i(sq_nxt),
    .v_o(sq_v), .ready_i(sq_rdy), .d_o(sq_d)
  );

  // Square root chain.
  logic          sr_v   [RB+1];
  logic          sr_rdy [RB+1];
  logic [NW-1:0] sr_n   [RB+1];
  logic [RB:0]   sr_rem [RB+1];
  logic [RB-1:0] sr_root[RB+1];
  st0_t          sr_side[RB+1];

  assign sr_v[0]    = sq_v;
  assign sq_rdy     = sr_rdy[0];
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_side[0] = sq_d.s;
  assign sr_n[0]    = (sq_d.s.mode == rts_pkg::CMD_SHORT)
                    ? NW'(sq_d.sq1) - NW'(sq_d.sq2)
                    : NW'(sq_d.sq1) + NW'(sq_d.sq2);

  for (genvar g = 0; g < RB; g++) begin : g_sqrt
    rts_sqrt_cell #(.RB(RB), .IDX(g), .SIDE_W($bits(st0_t))) u_cell (
      .clk(clk), .rst_n(rst_n),
      .v_i(sr_v[g]), .ready_o(sr_rdy[g]), .n_i(sr_n[g]), .rem_i(sr_rem[g]),
      .root_i(sr_root[g]), .side_i(sr_side[g]),
      .v_o(sr_v[g+1]), .ready_i(sr_rdy[g+1]), .n_o(sr_n[g+1]), .rem_o(sr_rem[g+1]),
      .root_o(sr_root[g+1]), .side_o(sr_side[g+1])
    );
  end

  // Resolve the three sides, perimeter and leg product.
  post_t  post_nxt, post_d;
  logic   post_v, post_rdy;
  logic [L-1:0]  pa, pb;
  logic [RB-1:0] pc;
  st0_t          ps;

  always_comb begin
    ps = sr_side[RB];
    if (ps.mode == rts_pkg::CMD_SHORT) begin
      pa = ps.s2;
      pb = sr_root[RB][L-1:0];
      pc = RB'(ps.s1);
    end else begin
      pa = ps.s1;
      pb = ps.s2;
      pc = sr_root[RB];
    end
    post_nxt.deg   = ps.deg;
    post_nxt.a     = pa;
    post_nxt.b     = pb;
    post_nxt.third = sr_root[RB];
    post_nxt.perim = (L+2)'(pa) + (L+2)'(pb) + (L+2)'(pc);
    post_nxt.prod  = (2*L)'(pa) * (2*L)'(pb);
  end

  rts_pipe_reg #(.W($bits(post_t))) u_post_reg (
    .clk(clk), .rst_n(rst_n), .v_i(sr_v[RB]), .ready_o(sr_rdy[RB]), .d_i(post_nxt),
    .v_o(post_v), .ready_i(post_rdy), .d_o(post_d)
  );

  // Normalization shifter, largest shift first.
  logic                   nm_v   [NS+1];
  logic                   nm_rdy [NS+1];
  logic [rts_pkg::CW-1:0] nm_x   [NS+1];
  logic [rts_pkg::CW-1:0] nm_y   [NS+1];
  post_t                  nm_side[NS+1];

  assign nm_v[0]    = post_v;
  assign post_rdy   = nm_rdy[0];
  assign nm_x[0]    = rts_pkg::CW'(post_d.b);
  assign nm_y[0]    = rts_pkg::CW'(post_d.a);
  assign nm_side[0] = post_d;

  for (genvar g = 0; g < NS; g++) begin : g_norm
    rts_norm_cell #(.K(1 << (NS - 1 - g)), .SIDE_W($bits(post_t))) u_cell (
      .clk(clk), .rst_n(rst_n),
      .v_i(nm_v[g]), .ready_o(nm_rdy[g]), .x_i(nm_x[g]), .y_i(nm_y[g]),
      .side_i(nm_side[g]),
      .v_o(nm_v[g+1]), .ready_i(nm_rdy[g+1]), .x_o(nm_x[g+1]), .y_o(nm_y[g+1]),
      .side_o(nm_side[g+1])
    );
  end

  // CORDIC vectoring chain.
  logic                          cr_v   [N+1];
  logic                          cr_rdy [N+1];
  logic [rts_pkg::CW-1:0]        cr_x   [N+1];
  logic [rts_pkg::CW-1:0]        cr_y   [N+1];
  logic signed [rts_pkg::ZW-1:0] cr_z   [N+1];
  post_t                         cr_side[N+1];

  assign cr_v[0]    = nm_v[NS];
  assign nm_rdy[NS] = cr_rdy[0];
  assign cr_x[0]    = nm_x[NS];
  assign cr_y[0]    = nm_y[NS];
  assign cr_z[0]    = '0;
  assign cr_side[0] = nm_side[NS];

  for (genvar g = 0; g < N; g++) begin : g_cordic
    rts_cordic_cell #(.I(g), .SIDE_W($bits(post_t))) u_cell (
      .clk(clk), .rst_n(rst_n),
      .v_i(cr_v[g]), .ready_o(cr_rdy[g]), .x_i(cr_x[g]), .y_i(cr_y[g]), .z_i(cr_z[g]),
      .side_i(cr_side[g]),
      .v_o(cr_v[g+1]), .ready_i(cr_rdy[g+1]), .x_o(cr_x[g+1]), .y_o(cr_y[g+1]),
      .z_o(cr_z[g+1]), .side_o(cr_side[g+1])
    );
  end

  // Final clamping, saturation and degenerate handling.
  rts_pkg::out_word_t out_nxt, out_d;
  logic               out_v;
  post_t              fs;
  logic signed [rts_pkg::ZW-1:0] fz;
  logic [rts_pkg::ANGLE_W-1:0]   alpha;
  logic [TW-1:0]  th_ext;
  logic [PMW-1:0] pm_ext;
  logic [AXW-1:0] pr_ext;

  always_comb begin
    fs     = cr_side[N];
    fz     = cr_z[N];
    th_ext = TW'(fs.third);
    pm_ext = PMW'(fs.perim);
    pr_ext = AXW'(fs.prod);
    priority if (fs.a == '0) begin
      alpha = '0;
    end else if (fs.b == '0) begin
      alpha = rts_pkg::ANGLE_NINETY;
    end else if (fz < 0) begin
      alpha = '0;
    end else if (fz > $signed({2'b00, rts_pkg::ANGLE_NINETY})) begin
      alpha = rts_pkg::ANGLE_NINETY;
    end else begin
      alpha = fz[rts_pkg::ANGLE_W-1:0];
    end
    if (fs.deg) begin
      out_nxt = '0;
      out_nxt.status = 1'b1;
    end else begin
      out_nxt.third_side = (th_ext > TW'(rts_pkg::SIDE_MAX)) ? rts_pkg::SIDE_MAX
                         : th_ext[rts_pkg::SIDE_OW-1:0];
      out_nxt.alpha_deg  = alpha;
      out_nxt.beta_deg   = rts_pkg::ANGLE_NINETY - alpha;
      out_nxt.perimeter  = (pm_ext > PMW'(rts_pkg::PERIM_MAX)) ? rts_pkg::PERIM_MAX
                         : pm_ext[rts_pkg::PERIM_W-1:0];
      // Products of 2^65 and above saturate; below that the halved product is cut to its low 63 bits.
      out_nxt.area       = ((pr_ext >> 65) != '0) ? rts_pkg::AREA_MAX
                         : pr_ext[rts_pkg::AREA_W:1];
      out_nxt.status     = 1'b0;
    end
  end

  rts_pipe_reg #(.W($bits(rts_pkg::out_word_t))) u_out_reg (
    .clk(clk), .rst_n(rst_n), .v_i(cr_v[N]), .ready_o(cr_rdy[N]), .d_i(out_nxt),
    .v_o(out_v), .ready_i(out_ch.ready), .d_o(out_d)
  );

  assign out_ch.valid      = out_v;
  assign out_ch.third_side = out_d.third_side;
  assign out_ch.alpha_deg  = out_d.alpha_deg;
  assign out_ch.beta_deg   = out_d.beta_deg;
  assign out_ch.perimeter  = out_d.perimeter;
  assign out_ch.area       = out_d.area;
  assign out_ch.status     = out_d.status;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v && out_d.status |-> out_d.third_side == '0 && out_d.alpha_deg == '0
      && out_d.perimeter == '0 && out_d.area == '0)
    else $error("degenerate word carries nonzero results");

  a_angle_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_v && !out_d.status |->
      (24'(out_d.alpha_deg) + 24'(out_d.beta_deg)) == 24'(rts_pkg::ANGLE_NINETY))
    else $error("alpha and beta do not add to ninety degrees");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v |-> out_d.alpha_deg <= rts_pkg::ANGLE_NINETY)
    else $error("alpha beyond ninety degrees");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v && !out_ch.ready |=> out_v && $stable(out_d))
    else $error("stalled result word changed");
endmodule
